// ===== sv/pbfe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbfe_pkg
// Shared types and constants of the protobuf field extractor.
// ----------------------------------------------------------------------------
package pbfe_pkg;

   localparam int LENGTH_BITS_DEFAULT = 32;
   localparam int FIELD_WIDTH         = 29;
   localparam int COUNT_WIDTH         = 16;
   localparam int CSR_DATA_WIDTH      = 29;
   localparam int VARINT_WIDTH        = 64;
   localparam int FIFO_DEPTH          = 4;

   localparam logic [0:0] CSR_TARGET_FIELD = 1'b0;
   localparam logic [0:0] CSR_COPY_LIMIT   = 1'b1;

   localparam logic [FIELD_WIDTH-1:0] TARGET_RESET = 29'd1;
   localparam logic [COUNT_WIDTH-1:0] LIMIT_RESET  = 16'hFFFF;

   // last byte index of a varint (shift 63)
   localparam logic [3:0] VARINT_LAST_BYTE = 4'd9;

   localparam logic [2:0] WT_VARINT  = 3'd0;
   localparam logic [2:0] WT_FIXED64 = 3'd1;
   localparam logic [2:0] WT_LENGTH  = 3'd2;
   localparam logic [2:0] WT_FIXED32 = 3'd5;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_REPORT  = 1'b1;

   typedef enum logic [2:0] {
      PH_TAG,
      PH_SKIPVAR,
      PH_LENSKIP,
      PH_LENCOPY,
      PH_SKIPBYTE,
      PH_COPY,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic                   kind;
      logic [7:0]             out_byte;
      logic                   found;
      logic                   malformed;
      logic [COUNT_WIDTH-1:0] copied_length;
      logic                   last;
   } result_type;

   typedef struct packed {
      logic       pay_valid;
      result_type pay;
      logic       rep_valid;
      result_type rep;
   } push_type;

endpackage
`default_nettype wire

// ===== sv/pbfe_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbfe_req_if
// Request channel: one message byte with end-of-message mark.
// ----------------------------------------------------------------------------
interface pbfe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_message;

   modport source (output valid, data_byte, end_of_message, input ready);
   modport sink   (input valid, data_byte, end_of_message, output ready);
endinterface
`default_nettype wire

// ===== sv/pbfe_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbfe_rsp_if
// Result channel: payload byte or end-of-message report.
// ----------------------------------------------------------------------------
interface pbfe_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  out_byte;
   logic        found;
   logic        malformed;
   logic [15:0] copied_length;
   logic        last;

   modport source (output valid, kind, out_byte, found, malformed, copied_length, last,
                   input ready);
   modport sink   (input valid, kind, out_byte, found, malformed, copied_length, last,
                   output ready);
endinterface
`default_nettype wire

// ===== sv/pbfe_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbfe_parser
// Wire-format state machine: one byte per cycle while accept is high, emits payload and report.
// ----------------------------------------------------------------------------
module pbfe_parser #(
   parameter int LENGTH_BITS = pbfe_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                accept,
   input  wire logic [7:0]                          data_byte,
   input  wire logic                                end_of_message,
   input  wire logic                                csr_write_en,
   input  wire logic [0:0]                          csr_index,
   input  wire logic [pbfe_pkg::CSR_DATA_WIDTH-1:0] csr_write_data,
   output pbfe_pkg::push_type                       push
);

   localparam int CW = pbfe_pkg::COUNT_WIDTH;
   localparam int VW = pbfe_pkg::VARINT_WIDTH;

   pbfe_pkg::phase_type                 phase_ff, phase_in, phase_step;
   logic [VW-1:0]                       accum_ff, accum_in, accum_step;
   logic [3:0]                          idx_ff, idx_in, idx_step;
   logic [LENGTH_BITS-1:0]              rem_ff, rem_in, rem_step;
   logic [CW-1:0]                       copied_ff, copied_in, copied_step;
   logic                                found_ff, found_in, found_step;
   logic                                error_ff, error_in, error_step;
   logic [pbfe_pkg::FIELD_WIDTH-1:0]    target_ff;
   logic [CW-1:0]                       limit_ff;

   logic [5:0]             shift;
   logic [VW-1:0]          accum_fed;
   logic                   var_cont;
   logic                   var_over;
   logic [2:0]             tag_wire;
   logic                   tag_match;
   logic                   len_sat;
   logic [LENGTH_BITS-1:0] len_val;
   logic [LENGTH_BITS-1:0] rem_dec;
   logic [CW-1:0]          copied_inc;

   assign shift      = 6'((7'({3'b000, idx_ff}) << 3) - 7'({3'b000, idx_ff}));
   assign accum_fed  = accum_ff | ({57'd0, data_byte[6:0]} << shift);
   assign var_cont   = data_byte[7];
   assign var_over   = var_cont && (idx_ff == pbfe_pkg::VARINT_LAST_BYTE);
   assign tag_wire   = accum_fed[2:0];
   assign tag_match  = accum_fed[VW-1:3] == {32'd0, target_ff};
   assign len_sat    = (accum_fed >> LENGTH_BITS) != '0;
   assign len_val    = len_sat ? {LENGTH_BITS{1'b1}} : accum_fed[LENGTH_BITS-1:0];
   assign rem_dec    = (rem_ff != '0) ? rem_ff - LENGTH_BITS'(1) : rem_ff;
   assign copied_inc = copied_ff + CW'(1);

   // next state
   always_comb begin
      phase_step  = phase_ff;
      accum_step  = accum_ff;
      idx_step    = idx_ff;
      rem_step    = rem_ff;
      copied_step = copied_ff;
      found_step  = found_ff;
      error_step  = error_ff;
      case (phase_ff)
         pbfe_pkg::PH_TAG, pbfe_pkg::PH_SKIPVAR,
         pbfe_pkg::PH_LENSKIP, pbfe_pkg::PH_LENCOPY: begin
            if (var_over) begin
               accum_step = '0;
               idx_step   = '0;
               error_step = 1'b1;
               phase_step = pbfe_pkg::PH_DONE;
            end else if (var_cont) begin
               accum_step = accum_fed;
               idx_step   = idx_ff + 4'd1;
            end else begin
               accum_step = '0;
               idx_step   = '0;
               case (phase_ff)
                  pbfe_pkg::PH_TAG: begin
                     case (tag_wire)
                        pbfe_pkg::WT_VARINT: phase_step = pbfe_pkg::PH_SKIPVAR;
                        pbfe_pkg::WT_FIXED64: begin
                           rem_step   = LENGTH_BITS'(8);
                           phase_step = pbfe_pkg::PH_SKIPBYTE;
                        end
                        pbfe_pkg::WT_FIXED32: begin
                           rem_step   = LENGTH_BITS'(4);
                           phase_step = pbfe_pkg::PH_SKIPBYTE;
                        end
                        pbfe_pkg::WT_LENGTH: begin
                           phase_step = tag_match ? pbfe_pkg::PH_LENCOPY
                                                  : pbfe_pkg::PH_LENSKIP;
                        end
                        default: begin
                           error_step = 1'b1;
                           phase_step = pbfe_pkg::PH_DONE;
                        end
                     endcase
                  end
                  pbfe_pkg::PH_SKIPVAR: phase_step = pbfe_pkg::PH_TAG;
                  pbfe_pkg::PH_LENSKIP: begin
                     rem_step   = len_val;
                     phase_step = (len_val == '0) ? pbfe_pkg::PH_TAG : pbfe_pkg::PH_SKIPBYTE;
                  end
                  default: begin
                     rem_step   = len_val;
                     found_step = 1'b1;
                     phase_step = (len_val == '0 || limit_ff == '0) ? pbfe_pkg::PH_DONE
                                                                     : pbfe_pkg::PH_COPY;
                  end
               endcase
            end
         end
         pbfe_pkg::PH_SKIPBYTE: begin
            rem_step = rem_dec;
            if (rem_dec == '0) begin
               phase_step = pbfe_pkg::PH_TAG;
            end
         end
         pbfe_pkg::PH_COPY: begin
            rem_step    = rem_dec;
            copied_step = copied_inc;
            if (rem_dec == '0 || copied_inc >= limit_ff) begin
               phase_step = pbfe_pkg::PH_DONE;
            end
         end
         default: ;
      endcase

      if (accept && end_of_message) begin
         phase_in  = pbfe_pkg::PH_TAG;
         accum_in  = '0;
         idx_in    = '0;
         rem_in    = '0;
         copied_in = '0;
         found_in  = 1'b0;
         error_in  = 1'b0;
      end else if (accept) begin
         phase_in  = phase_step;
         accum_in  = accum_step;
         idx_in    = idx_step;
         rem_in    = rem_step;
         copied_in = copied_step;
         found_in  = found_step;
         error_in  = error_step;
      end else begin
         phase_in  = phase_ff;
         accum_in  = accum_ff;
         idx_in    = idx_ff;
         rem_in    = rem_ff;
         copied_in = copied_ff;
         found_in  = found_ff;
         error_in  = error_ff;
      end
   end

   // outputs
   always_comb begin
      push.pay_valid         = accept && (phase_ff == pbfe_pkg::PH_COPY);
      push.pay.kind          = pbfe_pkg::KIND_PAYLOAD;
      push.pay.out_byte      = data_byte;
      push.pay.found         = 1'b0;
      push.pay.malformed     = 1'b0;
      push.pay.copied_length = '0;
      push.pay.last          = 1'b0;
      push.rep_valid         = accept && end_of_message;
      push.rep.kind          = pbfe_pkg::KIND_REPORT;
      push.rep.out_byte      = 8'd0;
      push.rep.found         = found_step;
      push.rep.malformed     = error_step;
      push.rep.copied_length = copied_step;
      push.rep.last          = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= pbfe_pkg::PH_TAG;
         accum_ff  <= '0;
         idx_ff    <= '0;
         rem_ff    <= '0;
         copied_ff <= '0;
         found_ff  <= 1'b0;
         error_ff  <= 1'b0;
         target_ff <= pbfe_pkg::TARGET_RESET;
         limit_ff  <= pbfe_pkg::LIMIT_RESET;
      end else begin
         phase_ff  <= phase_in;
         accum_ff  <= accum_in;
         idx_ff    <= idx_in;
         rem_ff    <= rem_in;
         copied_ff <= copied_in;
         found_ff  <= found_in;
         error_ff  <= error_in;
         if (csr_write_en && csr_index == pbfe_pkg::CSR_TARGET_FIELD) begin
            target_ff <= csr_write_data;
         end
         if (csr_write_en && csr_index == pbfe_pkg::CSR_COPY_LIMIT) begin
            limit_ff <= csr_write_data[CW-1:0];
         end
      end
   end

endmodule
`default_nettype wire

// ===== sv/pbfe_out_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbfe_out_fifo
// Result queue: takes up to two results a cycle, delivers one per pop.
// ----------------------------------------------------------------------------
module pbfe_out_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  pbfe_pkg::push_type        push,
   input  wire logic                 pop,
   output pbfe_pkg::result_type      head,
   output logic                      not_empty,
   output logic                      has_room
);

   localparam int DEPTH = pbfe_pkg::FIFO_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int NW    = $clog2(DEPTH + 1);

   pbfe_pkg::result_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [NW-1:0] count_ff, count_in;
   logic [PW-1:0] rep_slot;

   assign rep_slot  = wr_ff + PW'(push.pay_valid);
   assign wr_in     = rep_slot + PW'(push.rep_valid);
   assign rd_in     = rd_ff + PW'(pop);
   assign count_in  = count_ff + NW'(push.pay_valid) + NW'(push.rep_valid) - NW'(pop);
   assign head      = mem_ff[rd_ff];
   assign not_empty = count_ff != '0;
   assign has_room  = count_ff <= NW'(DEPTH - 2);

   always_ff @(posedge clock) begin
      if (push.pay_valid) begin
         mem_ff[wr_ff] <= push.pay;
      end
      if (push.rep_valid) begin
         mem_ff[rep_slot] <= push.rep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/protobuf_field_extractor.sv =====
`default_nettype none
// A result is written into the result queue when its request is accepted.
// Throughput: one request per cycle while ready is high; each accepted byte updates the parse state.
// A final byte that also carries payload gives two results, drained one per cycle while rsp ready is high
// from a four-entry result queue; ready is low while fewer than two slots are free.
// Reset (synchronous, active high) clears the parse state and the queue and
// loads target_field = 1, copy_limit = 65535.
// ----------------------------------------------------------------------------
// protobuf_field_extractor
// Extracts the payload of one length-delimited protobuf field from a byte stream.
// ----------------------------------------------------------------------------
module protobuf_field_extractor #(
   parameter int LENGTH_BITS = pbfe_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   pbfe_req_if.sink                                 req_bus,
   pbfe_rsp_if.source                               rsp_bus,
   input  wire logic                                csr_write_en,
   input  wire logic [0:0]                          csr_index,
   input  wire logic [pbfe_pkg::CSR_DATA_WIDTH-1:0] csr_write_data
);

   pbfe_pkg::push_type   push;
   pbfe_pkg::result_type head;
   logic                 accept;
   logic                 pop;
   logic                 not_empty;
   logic                 has_room;

   assign req_bus.ready = has_room;
   assign accept        = req_bus.valid && has_room;
   assign pop           = not_empty && rsp_bus.ready;

   pbfe_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .data_byte      (req_bus.data_byte),
      .end_of_message (req_bus.end_of_message),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .push           (push)
   );

   pbfe_out_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .has_room  (has_room)
   );

   assign rsp_bus.valid         = not_empty;
   assign rsp_bus.kind          = head.kind;
   assign rsp_bus.out_byte      = head.out_byte;
   assign rsp_bus.found         = head.found;
   assign rsp_bus.malformed     = head.malformed;
   assign rsp_bus.copied_length = head.copied_length;
   assign rsp_bus.last          = head.last;

endmodule
`default_nettype wire

// ===== sv/pbfe_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbfe_checker
// Port-level checks of the field extractor, bound to the top level.
// ----------------------------------------------------------------------------
module pbfe_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_kind,
   input wire logic [7:0]  rsp_out_byte,
   input wire logic        rsp_found,
   input wire logic        rsp_malformed,
   input wire logic [15:0] rsp_copied_length,
   input wire logic        rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_out_byte)
         && $stable(rsp_copied_length) && $stable(rsp_last))
      else $error("stalled result changed");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == pbfe_pkg::KIND_PAYLOAD |->
         !rsp_last && !rsp_found && !rsp_malformed && rsp_copied_length == 16'd0)
      else $error("payload result carries report fields");

   a_report_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == pbfe_pkg::KIND_REPORT |-> rsp_last && rsp_out_byte == 8'd0)
      else $error("report without last or with data");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("queue not empty after reset");

endmodule

bind protobuf_field_extractor pbfe_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_kind          (rsp_bus.kind),
   .rsp_out_byte      (rsp_bus.out_byte),
   .rsp_found         (rsp_bus.found),
   .rsp_malformed     (rsp_bus.malformed),
   .rsp_copied_length (rsp_bus.copied_length),
   .rsp_last          (rsp_bus.last)
);
`default_nettype wire
